// File: design/dvs_pkg.sv
// ----------------------------------------------------------------------------
// Distance-to-volume smoother package
// Shared constants, derived widths, reciprocal constants and types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dvs_pkg;

  // Block configuration.
  localparam int WINDOW_LENGTH = 40;
  localparam int NEAR_DISTANCE = 3;
  localparam int FAR_DISTANCE  = 50;

  // Field widths of the channels.
  localparam int SAMPLE_W = 10;
  localparam int CEIL_W   = 7;
  localparam int VOL_W    = 7;

  // A stored sample never exceeds the far limit, and neither does the average.
  localparam int ENTRY_W = $clog2(FAR_DISTANCE + 1);
  localparam int AVG_W   = ENTRY_W;
  localparam int SUM_W   = $clog2(WINDOW_LENGTH * FAR_DISTANCE + 1);

  // Average: floor(sum / WINDOW_LENGTH) as (sum * AVG_MULT) >> AVG_SHIFT,
  // exact for every sum below 2**SUM_W.
  localparam int AVG_SHIFT  = SUM_W + $clog2(WINDOW_LENGTH);
  localparam int AVG_MULT   = ((2 ** AVG_SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;
  localparam int AVG_PROD_W = AVG_SHIFT + AVG_W;

  // Linear map: floor(ceiling * (far - avg) / span), span kept nonzero.
  localparam bit DEGENERATE = (FAR_DISTANCE <= NEAR_DISTANCE);
  localparam int SPAN       = DEGENERATE ? 1 : (FAR_DISTANCE - NEAR_DISTANCE);
  localparam int SPAN_W     = $clog2(SPAN + 1);
  localparam int NUM_W      = CEIL_W + SPAN_W;
  localparam int VOL_SHIFT  = NUM_W + $clog2(SPAN);
  localparam int VOL_MULT   = ((2 ** VOL_SHIFT) + SPAN - 1) / SPAN;
  localparam int VOL_PROD_W = VOL_SHIFT + VOL_W;

  // How the final stage forms the volume.
  typedef enum logic [1:0] {
    MAP_ZERO  = 2'd0,
    MAP_CEIL  = 2'd1,
    MAP_SCALE = 2'd2
  } map_mode_t;

  // Item leaving the window stage: updated sum plus the side fields.
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CEIL_W-1:0] ceiling;
    logic              mute;
  } win_item_t;

endpackage

`default_nettype wire

// File: design/dvs_if.sv
// ----------------------------------------------------------------------------
// Distance-to-volume smoother channels
// Valid/ready interfaces for the sample channel and the volume channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dvs_in_if;
  logic                          valid;
  logic                          ready;
  logic [dvs_pkg::SAMPLE_W-1:0]  distance_sample;
  logic [dvs_pkg::CEIL_W-1:0]    max_volume;
  logic                          mute;

  modport source (output valid, output distance_sample, output max_volume,
                  output mute, input ready);
  modport sink   (input valid, input distance_sample, input max_volume,
                  input mute, output ready);
endinterface

interface dvs_out_if;
  logic                       valid;
  logic                       ready;
  logic [dvs_pkg::VOL_W-1:0]  volume;

  modport source (output valid, output volume, input ready);
  modport sink   (input valid, input volume, output ready);
endinterface

`default_nettype wire

// File: design/distance_to_volume_smoother.sv
// Path: a result passes the window, average, numerator and output registers.
// Throughput: one item per cycle while the output is not stalled; the running sum is registered.
// The window is a shift line of the last WINDOW_LENGTH stored samples.
// Reset (rst_n low, synchronous) zeroes the window and the sum and empties
// all stages; the block is ready to accept items right after reset.
// ----------------------------------------------------------------------------
// Distance-to-volume smoother
// Averages recent distance samples and maps the average to a volume level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module distance_to_volume_smoother (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dvs_in_if.sink     in_item,
  dvs_out_if.source  out_item
);

  dvs_pkg::win_item_t win_item;
  logic               win_valid;
  logic               win_ready;

  // Sample window and running sum.
  dvs_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .win_item  (win_item),
    .win_valid (win_valid),
    .win_ready (win_ready)
  );

  // Average and linear volume map.
  dvs_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_item  (win_item),
    .win_valid (win_valid),
    .win_ready (win_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: design/dvs_window.sv
// ----------------------------------------------------------------------------
// Sample window
// Shift line of the most recent samples with a running sum, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dvs_window (
  input  wire logic              clk,
  input  wire logic              rst_n,
  dvs_in_if.sink                 in_item,
  output dvs_pkg::win_item_t     win_item,
  output logic                   win_valid,
  input  wire logic              win_ready
);

  logic [dvs_pkg::ENTRY_W-1:0] ring_r [dvs_pkg::WINDOW_LENGTH];
  logic [dvs_pkg::SUM_W-1:0]   sum_r;
  logic [dvs_pkg::SUM_W-1:0]   sum_nxt;
  logic                        valid_r;
  dvs_pkg::win_item_t          item_r;
  logic                        accept;
  logic                        store;
  logic [dvs_pkg::ENTRY_W-1:0] sample_entry;

  // The stage takes an item when empty or when its item moves on.
  assign in_item.ready = !valid_r || win_ready;
  assign accept        = in_item.valid && in_item.ready;
  assign store         = accept &&
                         (in_item.distance_sample <= dvs_pkg::SAMPLE_W'(dvs_pkg::FAR_DISTANCE));
  assign sample_entry  = in_item.distance_sample[dvs_pkg::ENTRY_W-1:0];

  // Running sum: the oldest entry leaves, the new sample enters.
  always_comb begin
    sum_nxt = sum_r;
    if (store) begin
      sum_nxt = sum_r - dvs_pkg::SUM_W'(ring_r[dvs_pkg::WINDOW_LENGTH-1])
                      + dvs_pkg::SUM_W'(sample_entry);
    end
  end

  // Window contents and the sum, all zero after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dvs_pkg::WINDOW_LENGTH; i++) begin
        ring_r[i] <= '0;
      end
      sum_r <= '0;
    end else if (store) begin
      ring_r[0] <= sample_entry;
      for (int i = 1; i < dvs_pkg::WINDOW_LENGTH; i++) begin
        ring_r[i] <= ring_r[i-1];
      end
      sum_r <= sum_nxt;
    end
  end

  // Output register of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_item.ready) begin
      valid_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.sum     <= sum_nxt;
      item_r.ceiling <= in_item.max_volume;
      item_r.mute    <= in_item.mute;
    end
  end

  assign win_item  = item_r;
  assign win_valid = valid_r;

endmodule

`default_nettype wire

// File: design/dvs_map.sv
// ----------------------------------------------------------------------------
// Volume mapper
// Three stages: average, numerator and scaled volume, with backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dvs_map (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dvs_pkg::win_item_t win_item,
  input  wire logic              win_valid,
  output logic                   win_ready,
  dvs_out_if.source              out_item
);

  // Average stage.
  logic                           avg_v_r;
  logic [dvs_pkg::AVG_W-1:0]      avg_r;
  logic [dvs_pkg::CEIL_W-1:0]     avg_ceil_r;
  logic                           avg_mute_r;
  logic [dvs_pkg::AVG_PROD_W-1:0] avg_prod;
  logic                           avg_ready;

  // Numerator stage.
  logic                           num_v_r;
  logic [dvs_pkg::NUM_W-1:0]      num_r;
  logic [dvs_pkg::NUM_W-1:0]      num_nxt;
  logic [dvs_pkg::CEIL_W-1:0]     num_ceil_r;
  dvs_pkg::map_mode_t             num_mode_r;
  dvs_pkg::map_mode_t             mode_nxt;
  logic [dvs_pkg::AVG_W-1:0]      diff;
  logic                           num_ready;

  // Output stage.
  logic                           out_v_r;
  logic [dvs_pkg::VOL_W-1:0]      vol_r;
  logic [dvs_pkg::VOL_W-1:0]      vol_nxt;
  logic [dvs_pkg::VOL_PROD_W-1:0] vol_prod;
  logic                           out_ready;

  // Each stage moves when it is empty or its item moves on.
  assign out_ready = !out_v_r || out_item.ready;
  assign num_ready = !num_v_r || out_ready;
  assign avg_ready = !avg_v_r || num_ready;
  assign win_ready = avg_ready;

  // Division of the sum by the window length through its reciprocal.
  assign avg_prod = dvs_pkg::AVG_PROD_W'(win_item.sum) *
                    dvs_pkg::AVG_PROD_W'(dvs_pkg::AVG_MULT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_v_r <= 1'b0;
    end else if (avg_ready) begin
      avg_v_r <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (avg_ready && win_valid) begin
      avg_r      <= avg_prod[dvs_pkg::AVG_PROD_W-1 -: dvs_pkg::AVG_W];
      avg_ceil_r <= win_item.ceiling;
      avg_mute_r <= win_item.mute;
    end
  end

  // Classify the average and form ceiling * (far - avg).
  assign diff = dvs_pkg::AVG_W'(dvs_pkg::FAR_DISTANCE) - avg_r;

  always_comb begin
    num_nxt = dvs_pkg::NUM_W'(avg_ceil_r) * dvs_pkg::NUM_W'(diff[dvs_pkg::SPAN_W-1:0]);
    if (avg_mute_r) begin
      mode_nxt = dvs_pkg::MAP_ZERO;
    end else if (int'(avg_r) < dvs_pkg::NEAR_DISTANCE) begin
      mode_nxt = dvs_pkg::MAP_CEIL;
    end else if (dvs_pkg::DEGENERATE || (int'(avg_r) > dvs_pkg::FAR_DISTANCE)) begin
      mode_nxt = dvs_pkg::MAP_ZERO;
    end else begin
      mode_nxt = dvs_pkg::MAP_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_v_r <= 1'b0;
    end else if (num_ready) begin
      num_v_r <= avg_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (num_ready && avg_v_r) begin
      num_r      <= num_nxt;
      num_ceil_r <= avg_ceil_r;
      num_mode_r <= mode_nxt;
    end
  end

  // Division of the numerator by the span through its reciprocal.
  assign vol_prod = dvs_pkg::VOL_PROD_W'(num_r) * dvs_pkg::VOL_PROD_W'(dvs_pkg::VOL_MULT);

  always_comb begin
    case (num_mode_r)
      dvs_pkg::MAP_CEIL:  vol_nxt = num_ceil_r;
      dvs_pkg::MAP_SCALE: vol_nxt = vol_prod[dvs_pkg::VOL_PROD_W-1 -: dvs_pkg::VOL_W];
      default:            vol_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ready) begin
      out_v_r <= num_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && num_v_r) begin
      vol_r <= vol_nxt;
    end
  end

  assign out_item.valid  = out_v_r;
  assign out_item.volume = vol_r;

endmodule

`default_nettype wire

// File: design/dvs_checker.sv
// ----------------------------------------------------------------------------
// Distance-to-volume smoother checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dvs_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [dvs_pkg::VOL_W-1:0] volume
);

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(volume))
    else $error("stalled result item changed or vanished");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item shown right after reset");

  // With the output drained every cycle the input never stalls.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is taken");

  // Reset leaves the block ready to take an item.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind distance_to_volume_smoother dvs_checker u_dvs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_item.ready),
  .out_valid (out_item.valid),
  .out_ready (out_item.ready),
  .volume    (out_item.volume)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance-to-volume smoother testbench
// Drives distance items through the sample channel with random gaps and
// checks every volume item against a windowed-average predictor. Includes
// one long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------

module tb;

  // Tracks the averaging window and holds the volumes still to come out.
  class volume_scoreboard;
    bit [dvs_pkg::ENTRY_W-1:0] window_ring [dvs_pkg::WINDOW_LENGTH];
    int unsigned               next_slot;
    int unsigned               window_total;
    bit [dvs_pkg::VOL_W-1:0]   pending_volumes [$];
    int unsigned               mismatches;

    function new();
      foreach (window_ring[i]) window_ring[i] = '0;
      next_slot    = 0;
      window_total = 0;
      mismatches   = 0;
    endfunction

    // Updates the window for one accepted item and queues its volume.
    function void note_sample(bit [dvs_pkg::SAMPLE_W-1:0] sample_cm,
                              bit [dvs_pkg::CEIL_W-1:0] ceiling, bit muted);
      int unsigned avg;
      int unsigned level;
      if (sample_cm <= dvs_pkg::FAR_DISTANCE) begin
        window_total = window_total - window_ring[next_slot] + sample_cm;
        window_ring[next_slot] = sample_cm[dvs_pkg::ENTRY_W-1:0];
        next_slot = (next_slot + 1 == dvs_pkg::WINDOW_LENGTH) ? 0 : next_slot + 1;
      end
      avg = window_total / dvs_pkg::WINDOW_LENGTH;
      if (avg < dvs_pkg::NEAR_DISTANCE) begin
        level = ceiling;
      end else if (avg > dvs_pkg::FAR_DISTANCE ||
                   dvs_pkg::FAR_DISTANCE <= dvs_pkg::NEAR_DISTANCE) begin
        level = 0;
      end else begin
        level = (ceiling * (dvs_pkg::FAR_DISTANCE - avg)) /
                (dvs_pkg::FAR_DISTANCE - dvs_pkg::NEAR_DISTANCE);
      end
      if (muted) level = 0;
      pending_volumes.push_back(level[dvs_pkg::VOL_W-1:0]);
    endfunction

    // Compares one volume item with the oldest pending expectation.
    function void check_volume(bit [dvs_pkg::VOL_W-1:0] actual);
      bit [dvs_pkg::VOL_W-1:0] expected;
      if (pending_volumes.size() == 0) begin
        $error("volume: no item pending, expected none, actual %0d", actual);
        mismatches++;
      end else begin
        expected = pending_volumes.pop_front();
        if (expected !== actual) begin
          $error("volume: expected %0d, actual %0d", expected, actual);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return pending_volumes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  dvs_in_if  in_if ();
  dvs_out_if out_if ();

  volume_scoreboard board = new();

  distance_to_volume_smoother dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if),
    .out_item (out_if)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offers one item after an optional gap and waits until it is taken.
  task automatic send_item(input bit [dvs_pkg::SAMPLE_W-1:0] sample_cm,
                           input bit [dvs_pkg::CEIL_W-1:0] ceiling,
                           input bit muted, input bit idle_on);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.distance_sample = sample_cm;
    in_if.max_volume      = ceiling;
    in_if.mute            = muted;
    in_if.valid           = 1'b1;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    board.note_sample(sample_cm, ceiling, muted);
    @(negedge clk);
  endtask

  // Volume receiver with random stalls and one long hold-off.
  initial begin
    int unsigned stall;
    int unsigned taken;
    bit          stall_on;
    bit          held;
    taken    = 0;
    stall_on = 1'b1;
    held     = 1'b0;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (taken % 64 == 0) stall_on = ($urandom_range(0, 3) != 0);
      stall = stall_on ? $urandom_range(0, 15) : 0;
      if (!held && taken >= 300) begin
        held  = 1'b1;
        stall = 250;
      end
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      board.check_volume(out_if.volume);
      taken++;
      @(negedge clk);
    end
  end

  // Reset, directed items, random bursts, drain and verdict.
  initial begin
    int unsigned sent;
    int unsigned burst_len;
    int          target;
    int          sample_cm;
    bit          idle_on;
    bit [dvs_pkg::CEIL_W-1:0] ceiling;

    rst_n = 1'b0;
    in_if.valid           = 1'b0;
    in_if.distance_sample = '0;
    in_if.max_volume      = '0;
    in_if.mute            = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Zero window: the volume follows the ceiling, including values above 100.
    send_item(10'd0, 7'd0, 1'b0, 1'b1);
    send_item(10'd0, 7'd127, 1'b0, 1'b1);
    send_item(10'd0, 7'd100, 1'b0, 1'b0);
    // Samples beyond the far limit are dropped, muted or not.
    send_item(10'd1023, 7'd100, 1'b0, 1'b0);
    send_item(dvs_pkg::SAMPLE_W'(dvs_pkg::FAR_DISTANCE + 1), 7'd100, 1'b0, 1'b1);
    send_item(10'd512, 7'd85, 1'b1, 1'b0);
    // A muted sample is still stored.
    send_item(dvs_pkg::SAMPLE_W'(dvs_pkg::FAR_DISTANCE), 7'd100, 1'b1, 1'b1);
    send_item(dvs_pkg::SAMPLE_W'(dvs_pkg::FAR_DISTANCE), 7'd127, 1'b0, 1'b0);
    // Fill with far-limit samples so the average climbs past the near limit.
    for (int i = 0; i < 16; i++) begin
      send_item(dvs_pkg::SAMPLE_W'(dvs_pkg::FAR_DISTANCE),
                (i % 2) ? 7'd127 : 7'd100, 1'b0, i < 8);
    end

    // Bursts around a target distance, with some noise items mixed in.
    sent = 0;
    while (sent < 1400) begin
      burst_len = $urandom_range(20, 90);
      target    = $urandom_range(0, dvs_pkg::FAR_DISTANCE);
      idle_on   = ($urandom_range(0, 2) != 0);
      for (int i = 0; i < burst_len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          sample_cm = $urandom_range(0, 1023);
        end else begin
          sample_cm = target + $urandom_range(0, 6) - 3;
          if (sample_cm < 0) sample_cm = 0;
          if (sample_cm > dvs_pkg::FAR_DISTANCE) sample_cm = dvs_pkg::FAR_DISTANCE;
        end
        if ($urandom_range(0, 9) == 0) ceiling = dvs_pkg::CEIL_W'($urandom_range(101, 127));
        else ceiling = dvs_pkg::CEIL_W'($urandom_range(0, 100));
        send_item(sample_cm[dvs_pkg::SAMPLE_W-1:0], ceiling, $urandom_range(0, 7) == 0,
                  idle_on);
        sent++;
      end
    end
    in_if.valid = 1'b0;

    // Drain, then wait for any stray volume items.
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
